FILE: design/rcl_pkg.sv
// ----------------------------------------------------------------------------
// rcl_pkg
// Shared types, codes and helpers for the rotator command link: input
// opcodes, result kinds, queued command layout and digit/angle arithmetic.
// ----------------------------------------------------------------------------
package rcl_pkg;

   // reply frame length in bytes
   localparam int ReplyLength = 12;
   localparam int CountBits   = $clog2(ReplyLength);

   // command queue between front and back
   localparam int QueueDepth  = 2;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   // frame bytes
   localparam logic [7:0] SyncByte  = 8'h57;
   localparam logic [7:0] DigitBase = 8'h30;
   localparam logic [7:0] SetTail   = 8'h2F;
   localparam logic [7:0] PollTail  = 8'h1F;
   localparam logic [7:0] EndByte   = 8'h20;
   localparam logic [7:0] ZeroByte  = 8'h00;

   // set frame byte positions
   localparam logic [3:0] PosSync    = 4'd0;
   localparam logic [3:0] PosAzFirst = 4'd1;
   localparam logic [3:0] PosAzLast  = 4'd4;
   localparam logic [3:0] PosAzRes   = 4'd5;
   localparam logic [3:0] PosElFirst = 4'd6;
   localparam logic [3:0] PosElLast  = 4'd9;
   localparam logic [3:0] PosElRes   = 4'd10;
   localparam logic [3:0] PosTail    = 4'd11;
   localparam logic [3:0] PosEnd     = 4'd12;

   localparam logic [3:0] ResReset = 4'd2;

   // angle offsets
   localparam logic signed [15:0] HalfDegOffset = 16'sd720;
   localparam logic signed [15:0] OffsetMax     = 16'sd9999;
   localparam logic [19:0]        TenthsOffset  = 20'd3600;

   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_POLL   = 2'd1,
      OP_RXBYTE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_TX  = 2'd0,
      KIND_POS = 2'd1,
      KIND_ERR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CMD_SET        = 3'd0,
      CMD_POLL       = 3'd1,
      CMD_REPORT     = 3'd2,
      CMD_REPORT_SET = 3'd3,
      CMD_ERROR      = 3'd4
   } cmd_code_type;

   // one queued command
   typedef struct packed {
      cmd_code_type      code;
      logic [13:0]       az_off;
      logic [13:0]       el_off;
      logic signed [19:0] az_tenths;
      logic signed [19:0] el_tenths;
   } cmd_type;

   typedef struct packed {
      logic [3:0]  digit;
      logic [13:0] rest;
   } digit_type;

   // saturate half-degree angle plus offset to 0..9999
   function automatic logic [13:0] offset_sat(input logic signed [14:0] half);
      logic signed [15:0] h;
      logic [13:0]        r;
      h = {half[14], half} + HalfDegOffset;
      if (h < 16'sd0) begin
         r = '0;
      end else if (h > OffsetMax) begin
         r = OffsetMax[13:0];
      end else begin
         r = h[13:0];
      end
      return r;
   endfunction

   // peel off one decimal digit by reciprocal multiply
   // place 3: thousands, 2: hundreds, 1: tens, 0: units
   function automatic digit_type split_digit(input logic [13:0] value,
                                             input logic [1:0]  place);
      logic [27:0] prod;
      logic [3:0]  d;
      logic [13:0] sub;
      digit_type   r;
      case (place)
         2'd3: begin
            prod = {14'd0, value} * 28'd8389;
            d    = prod[26:23];
            sub  = 14'({10'd0, d} * 14'd1000);
         end
         2'd2: begin
            prod = {14'd0, value} * 28'd41;
            d    = prod[15:12];
            sub  = 14'({10'd0, d} * 14'd100);
         end
         2'd1: begin
            prod = {14'd0, value} * 28'd205;
            d    = prod[14:11];
            sub  = 14'({10'd0, d} * 14'd10);
         end
         default: begin
            prod = '0;
            d    = value[3:0];
            sub  = value;
         end
      endcase
      r.digit = d;
      r.rest  = value - sub;
      return r;
   endfunction

   // four unsigned bytes as decimal digits, minus offset, in tenths
   function automatic logic signed [19:0] decode_tenths(input logic [7:0] b0,
                                                        input logic [7:0] b1,
                                                        input logic [7:0] b2,
                                                        input logic [7:0] b3);
      logic [19:0] sum;
      sum = {12'd0, b0} * 20'd1000 + {12'd0, b1} * 20'd100
          + {12'd0, b2} * 20'd10 + {12'd0, b3} - TenthsOffset;
      return $signed(sum);
   endfunction

endpackage

FILE: design/rcl_front.sv
// ----------------------------------------------------------------------------
// rcl_front
// Accepts request words, tracks link state (waiting flags, held set point,
// reply assembly) and issues one command per word that produces results.
// ----------------------------------------------------------------------------
module rcl_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_tuser,   // opcode
   input  logic [39:0]      req_tdata,   // azimuth_half_deg, elevation_half_deg, rx_byte
   input  logic             queue_full,
   output logic             push,
   output rcl_pkg::cmd_type push_cmd
);

   logic [7:0]  frame_ff [rcl_pkg::ReplyLength];
   logic [rcl_pkg::CountBits-1:0] count_ff, count_in;
   logic        status_wait_ff, status_wait_in;
   logic        set_wait_ff, set_wait_in;
   logic        pending_ff, pending_in;
   logic [13:0] held_az_ff, held_az_in;
   logic [13:0] held_el_ff, held_el_in;

   logic                 accept;
   logic                 idle;
   rcl_pkg::opcode_type  op;
   logic [7:0]           rx_byte;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign op         = rcl_pkg::opcode_type'(req_tuser);
   assign rx_byte    = req_tdata[37:30];
   assign idle       = !set_wait_ff && !status_wait_ff;

   // classify the word and update link state
   always_comb begin
      count_in       = count_ff;
      status_wait_in = status_wait_ff;
      set_wait_in    = set_wait_ff;
      pending_in     = pending_ff;
      held_az_in     = held_az_ff;
      held_el_in     = held_el_ff;
      push           = 1'b0;
      push_cmd.code      = rcl_pkg::CMD_POLL;
      push_cmd.az_off    = held_az_ff;
      push_cmd.el_off    = held_el_ff;
      push_cmd.az_tenths = rcl_pkg::decode_tenths(frame_ff[1], frame_ff[2],
                                                  frame_ff[3], frame_ff[4]);
      push_cmd.el_tenths = rcl_pkg::decode_tenths(frame_ff[6], frame_ff[7],
                                                  frame_ff[8], frame_ff[9]);
      if (accept) begin
         case (op)
            rcl_pkg::OP_SET: begin
               held_az_in = rcl_pkg::offset_sat(req_tdata[14:0]);
               held_el_in = rcl_pkg::offset_sat(req_tdata[29:15]);
               push_cmd.az_off = held_az_in;
               push_cmd.el_off = held_el_in;
               push_cmd.code   = rcl_pkg::CMD_SET;
               if (idle) begin
                  push        = 1'b1;
                  set_wait_in = 1'b1;
               end else begin
                  pending_in = 1'b1;
               end
            end
            rcl_pkg::OP_POLL: begin
               if (idle) begin
                  push           = 1'b1;
                  push_cmd.code  = rcl_pkg::CMD_POLL;
                  status_wait_in = 1'b1;
               end
            end
            rcl_pkg::OP_RXBYTE: begin
               if (count_ff == rcl_pkg::CountBits'(rcl_pkg::ReplyLength - 1)) begin
                  count_in = '0;
                  push     = 1'b1;
                  if (frame_ff[0] == rcl_pkg::SyncByte) begin
                     push_cmd.code  = rcl_pkg::CMD_REPORT;
                     status_wait_in = 1'b0;
                     set_wait_in    = 1'b0;
                     // re-send the held set point after a good reply
                     if (pending_ff) begin
                        push_cmd.code = rcl_pkg::CMD_REPORT_SET;
                        pending_in    = 1'b0;
                        set_wait_in   = 1'b1;
                     end
                  end else begin
                     push_cmd.code = rcl_pkg::CMD_ERROR;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         status_wait_ff <= 1'b0;
         set_wait_ff    <= 1'b0;
         pending_ff     <= 1'b0;
         held_az_ff     <= '0;
         held_el_ff     <= '0;
      end else begin
         count_ff       <= count_in;
         status_wait_ff <= status_wait_in;
         set_wait_ff    <= set_wait_in;
         pending_ff     <= pending_in;
         held_az_ff     <= held_az_in;
         held_el_ff     <= held_el_in;
      end
   end

   // store the received byte at the fill position
   always_ff @(posedge clock) begin
      if (accept && op == rcl_pkg::OP_RXBYTE) begin
         frame_ff[count_ff] <= rx_byte;
      end
   end

endmodule

FILE: design/rcl_queue.sv
// ----------------------------------------------------------------------------
// rcl_queue
// Short command FIFO that decouples the front from the result sequencer.
// ----------------------------------------------------------------------------
module rcl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rcl_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output rcl_pkg::cmd_type head,
   output logic             head_valid
);

   rcl_pkg::cmd_type entry_ff [rcl_pkg::QueueDepth];
   logic [rcl_pkg::QueuePtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rcl_pkg::QueuePtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rcl_pkg::QueuePtrBits:0]   fill_ff, fill_in;

   assign full       = fill_ff == (rcl_pkg::QueuePtrBits + 1)'(rcl_pkg::QueueDepth);
   assign head_valid = fill_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == rcl_pkg::QueuePtrBits'(rcl_pkg::QueueDepth - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == rcl_pkg::QueuePtrBits'(rcl_pkg::QueueDepth - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // hold the command words
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/rcl_back.sv
// ----------------------------------------------------------------------------
// rcl_back
// Result sequencer: walks the head command into the output register, one
// result per cycle while the output is not stalled, spelling frame digits one at a time.
// ----------------------------------------------------------------------------
module rcl_back (
   input  logic             clock,
   input  logic             reset,
   input  rcl_pkg::cmd_type head,
   input  logic             head_valid,
   output logic             pop,
   input  logic [3:0]       resolution,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [1:0]       rsp_tuser,   // kind
   output logic             rsp_tlast,   // last_of_run
   output logic [47:0]      rsp_tdata    // tx_byte, azimuth_tenths, elevation_tenths
);

   logic [3:0]  step_ff, step_in;
   logic [13:0] rem_ff, rem_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic        last_ff, last_in;
   logic [47:0] data_ff, data_in;

   logic               advance;
   logic [3:0]         pos;
   logic [1:0]         place;
   logic [13:0]        src;
   rcl_pkg::digit_type split;
   logic [7:0]         frame_byte;
   logic               in_frame;
   logic               frame_end;

   assign advance = head_valid && (!valid_ff || rsp_tready);

   // frame position: a report with a set behind it is one step ahead
   assign pos = (head.code == rcl_pkg::CMD_REPORT_SET) ? step_ff - 4'd1 : step_ff;
   assign in_frame = (head.code == rcl_pkg::CMD_SET) || (head.code == rcl_pkg::CMD_POLL)
                  || (head.code == rcl_pkg::CMD_REPORT_SET && step_ff != 4'd0);
   assign frame_end = pos == rcl_pkg::PosEnd;

   // pick the digit source and its decimal place
   always_comb begin
      place = 2'd0;
      src   = rem_ff;
      case (pos) inside
         [rcl_pkg::PosAzFirst:rcl_pkg::PosAzLast]: begin
            place = 2'(rcl_pkg::PosAzLast - pos);
            if (pos == rcl_pkg::PosAzFirst) begin
               src = head.az_off;
            end
         end
         [rcl_pkg::PosElFirst:rcl_pkg::PosElLast]: begin
            place = 2'(rcl_pkg::PosElLast - pos);
            if (pos == rcl_pkg::PosElFirst) begin
               src = head.el_off;
            end
         end
         default: begin
         end
      endcase
      split = rcl_pkg::split_digit(src, place);
   end

   // frame byte for the current position
   always_comb begin
      frame_byte = rcl_pkg::ZeroByte;
      if (head.code == rcl_pkg::CMD_POLL) begin
         case (pos)
            rcl_pkg::PosSync: frame_byte = rcl_pkg::SyncByte;
            rcl_pkg::PosTail: frame_byte = rcl_pkg::PollTail;
            rcl_pkg::PosEnd:  frame_byte = rcl_pkg::EndByte;
            default:          frame_byte = rcl_pkg::ZeroByte;
         endcase
      end else begin
         case (pos) inside
            rcl_pkg::PosSync: frame_byte = rcl_pkg::SyncByte;
            [rcl_pkg::PosAzFirst:rcl_pkg::PosAzLast],
            [rcl_pkg::PosElFirst:rcl_pkg::PosElLast]:
               frame_byte = rcl_pkg::DigitBase | {4'd0, split.digit};
            rcl_pkg::PosAzRes, rcl_pkg::PosElRes: frame_byte = {4'd0, resolution};
            rcl_pkg::PosTail: frame_byte = rcl_pkg::SetTail;
            rcl_pkg::PosEnd:  frame_byte = rcl_pkg::EndByte;
            default:          frame_byte = rcl_pkg::ZeroByte;
         endcase
      end
   end

   // build the next result and advance the step
   always_comb begin
      step_in  = step_ff;
      rem_in   = rem_ff;
      valid_in = valid_ff && !rsp_tready;
      kind_in  = kind_ff;
      last_in  = last_ff;
      data_in  = data_ff;
      pop      = 1'b0;
      if (advance) begin
         valid_in = 1'b1;
         rem_in   = split.rest;
         if (in_frame) begin
            kind_in = rcl_pkg::KIND_TX;
            last_in = frame_end;
            data_in = {40'd0, frame_byte};
         end else if (head.code == rcl_pkg::CMD_ERROR) begin
            kind_in = rcl_pkg::KIND_ERR;
            last_in = 1'b1;
            data_in = '0;
         end else begin
            kind_in = rcl_pkg::KIND_POS;
            last_in = head.code == rcl_pkg::CMD_REPORT;
            data_in = {head.el_tenths, head.az_tenths, 8'd0};
         end
         if (last_in) begin
            step_in = '0;
            pop     = 1'b1;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // payload of the output register
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = data_ff;

endmodule

FILE: design/rotator_command_link_top.sv
// A word is written into the command queue, then its first result into the
// single output register. Throughput: one result per cycle while rsp_tready
//   holds; a word yields 1, 13 or 14 results through the result sequencer's
//   output register; words with no result are absorbed at the front.
// Input is taken every cycle while the two-entry command queue has room.
// Reset is synchronous: flags, held set point, fill count cleared, resolution 2.
// ----------------------------------------------------------------------------
// rotator_command_link_top
// Rotator command link: frames set and poll commands for a serial rotator
// controller and decodes its twelve-byte replies.
// ----------------------------------------------------------------------------
module rotator_command_link_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // opcode
   input  logic [39:0] req_tdata,   // azimuth_half_deg[14:0], elevation_half_deg[29:15],
                                    // rx_byte[37:30], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last_of_run
   output logic [47:0] rsp_tdata,   // tx_byte[7:0], azimuth_tenths[27:8],
                                    // elevation_tenths[47:28]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data     // pulse_resolution
);

   logic [3:0]       resolution_ff;
   logic             push;
   logic             queue_full;
   logic             pop;
   logic             head_valid;
   rcl_pkg::cmd_type push_cmd;
   rcl_pkg::cmd_type head;

   // resolution register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_ff <= rcl_pkg::ResReset;
      end else if (csr_valid && csr_ready) begin
         resolution_ff <= csr_data;
      end
   end

   rcl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   rcl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   rcl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .resolution (resolution_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: design/rcl_checker.sv
// ----------------------------------------------------------------------------
// rcl_checker
// Port-level checks on the result stream of the rotator command link.
// ----------------------------------------------------------------------------
module rcl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast,
   input logic [47:0] rsp_tdata
);

   // hold a stalled result word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // reports and errors carry no transmit byte
   a_no_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rcl_pkg::KIND_TX |-> rsp_tdata[7:0] == 8'd0)
      else $error("non-transmit result carries a byte");

   // an error closes its run and carries no position
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rcl_pkg::KIND_ERR |-> rsp_tlast && rsp_tdata == '0)
      else $error("error result malformed");

   // a transmitted run ends exactly on the end byte
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rcl_pkg::KIND_TX
      |-> rsp_tlast == (rsp_tdata[7:0] == rcl_pkg::EndByte))
      else $error("frame end mismatch");

   // a report followed by more results is followed by a sync byte
   a_report_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == rcl_pkg::KIND_POS && !rsp_tlast
      ##1 rsp_tvalid |-> rsp_tuser == rcl_pkg::KIND_TX
                         && rsp_tdata[7:0] == rcl_pkg::SyncByte)
      else $error("report not followed by set frame");

endmodule

bind rotator_command_link_top rcl_checker u_rcl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata)
);
